@@ rtl/core/pmst_pkg.sv @@
// Package for the Prim spanning-tree engine: transaction payload types,
// command codes, controller states and the cell control bundle.
// Depends on nothing; every other file of the block but pmst_stream_if imports it.
package pmst_pkg;

	localparam int NODE_FIELD_BITS   = 3;
	localparam int WEIGHT_FIELD_BITS = 14;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_RUN   = 1'b1;

	typedef struct packed {
		logic                         command;
		logic [NODE_FIELD_BITS-1:0]   src_node;
		logic [NODE_FIELD_BITS-1:0]   to_node;
		logic [WEIGHT_FIELD_BITS-1:0] edge_weight;
		logic [NODE_FIELD_BITS-1:0]   start_node;
	} cmd_t;

	typedef struct packed {
		logic [NODE_FIELD_BITS-1:0]   child_node;
		logic [NODE_FIELD_BITS-1:0]   parent_node;
		logic [WEIGHT_FIELD_BITS-1:0] tree_weight;
		logic                         reachable;
		logic                         last;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT,
		ST_SCAN_GO,
		ST_SCAN_WAIT,
		ST_RELAX,
		ST_SETTLE,
		ST_DUMP
	} state_t;

	// Broadcast controls from the sequencer to every cell of the chain.
	typedef struct packed {
		logic init;
		logic mark;
		logic dump;
	} cell_ctl_t;

endpackage

@@ rtl/core/pmst_stream_if.sv @@
// Valid/ready stream interface used for the command and result channels.
// The payload type is a parameter; depends on nothing else.
interface pmst_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/pmst_adj_mem.sv @@
// Adjacency weight memory: one write port and one read port with
// registered read data. Uses pmst_pkg for house consistency only.
module pmst_adj_mem import pmst_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 14,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/pmst_cell.sv @@
// One node cell of the chain: holds the node's key, parent and flags,
// joins the minimum scan, takes its relax token and shifts out on dump.
// Depends on pmst_pkg for the control bundle.
module pmst_cell import pmst_pkg::*; #(
	parameter int NODE_COUNT  = 8,
	parameter int WEIGHT_BITS = 14,
	parameter int INDEX       = 0,
	localparam int NB = $clog2(NODE_COUNT),
	localparam int W  = WEIGHT_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_ctl_t     ctl,
	input  logic [NB-1:0] node_sel,
	input  logic          scan_in_valid,
	input  logic          scan_in_found,
	input  logic [W-1:0]  scan_in_best,
	input  logic [NB-1:0] scan_in_pick,
	output logic          scan_out_valid,
	output logic          scan_out_found,
	output logic [W-1:0]  scan_out_best,
	output logic [NB-1:0] scan_out_pick,
	input  logic          relax_in_valid,
	input  logic [NB-1:0] relax_in_col,
	input  logic [W-1:0]  relax_in_weight,
	output logic          relax_out_valid,
	output logic [NB-1:0] relax_out_col,
	output logic [W-1:0]  relax_out_weight,
	input  logic          rec_in_tree,
	input  logic [NB-1:0] rec_in_parent,
	input  logic [W-1:0]  rec_in_key,
	output logic          rec_tree,
	output logic [NB-1:0] rec_parent,
	output logic [W-1:0]  rec_key
);

	logic          reached_q;
	logic          in_tree_q;
	logic [W-1:0]  key_q;
	logic [NB-1:0] parent_q;
	logic          scan_valid_q, scan_found_q;
	logic [W-1:0]  scan_best_q;
	logic [NB-1:0] scan_pick_q;
	logic          relax_valid_q;
	logic [NB-1:0] relax_col_q;
	logic [W-1:0]  relax_weight_q;

	logic me, take, relax_hit;

	always_comb begin
		me = (node_sel == NB'(INDEX));
		// Taking on equal keys makes the highest index win the scan.
		take = reached_q && !in_tree_q && (!scan_in_found || key_q <= scan_in_best);
		relax_hit = relax_in_valid && (relax_in_col == NB'(INDEX)) &&
			(relax_in_weight != '0) && !in_tree_q &&
			(!reached_q || relax_in_weight < key_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q     <= 1'b0;
			in_tree_q     <= 1'b0;
			key_q         <= '1;
			scan_valid_q  <= 1'b0;
			relax_valid_q <= 1'b0;
		end else begin
			scan_valid_q  <= scan_in_valid;
			relax_valid_q <= relax_in_valid;
			if (ctl.dump) begin
				in_tree_q <= rec_in_tree;
				key_q     <= rec_in_key;
			end else if (ctl.init) begin
				key_q     <= me ? '0 : '1;
				reached_q <= me;
				in_tree_q <= 1'b0;
			end else begin
				if (ctl.mark && me) begin
					in_tree_q <= 1'b1;
				end
				if (relax_hit) begin
					reached_q <= 1'b1;
					key_q     <= relax_in_weight;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.dump) begin
			parent_q <= rec_in_parent;
		end else if (relax_hit) begin
			parent_q <= node_sel;
		end
		scan_found_q   <= scan_in_found || take;
		scan_best_q    <= take ? key_q : scan_in_best;
		scan_pick_q    <= take ? NB'(INDEX) : scan_in_pick;
		relax_col_q    <= relax_in_col;
		relax_weight_q <= relax_in_weight;
	end

	assign scan_out_valid   = scan_valid_q;
	assign scan_out_found   = scan_found_q;
	assign scan_out_best    = scan_best_q;
	assign scan_out_pick    = scan_pick_q;
	assign relax_out_valid  = relax_valid_q;
	assign relax_out_col    = relax_col_q;
	assign relax_out_weight = relax_weight_q;
	assign rec_tree         = in_tree_q;
	assign rec_parent       = parent_q;
	assign rec_key          = key_q;

endmodule

@@ rtl/core/pmst_ctrl.sv @@
// Sequencer of the spanning-tree engine: memory clearing, command intake,
// scan/relax rounds over the cell chain and the result register.
// Depends on pmst_pkg and pmst_stream_if.
module pmst_ctrl import pmst_pkg::*; #(
	parameter int NODE_COUNT  = 8,
	parameter int WEIGHT_BITS = 14,
	localparam int NB = $clog2(NODE_COUNT),
	localparam int W  = WEIGHT_BITS,
	localparam int AW = $clog2(NODE_COUNT * NODE_COUNT)
) (
	input  logic          clk,
	input  logic          arst_n,
	pmst_stream_if.sink   cmd,
	pmst_stream_if.source res,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [W-1:0]  mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [W-1:0]  mem_rdata,
	output cell_ctl_t     ctl,
	output logic [NB-1:0] node_sel,
	output logic          scan_head,
	output logic          relax_head,
	output logic [NB-1:0] relax_col_head,
	output logic [W-1:0]  relax_weight_head,
	input  logic          scan_tail,
	input  logic          found_tail,
	input  logic [W-1:0]  best_tail,
	input  logic [NB-1:0] pick_tail,
	input  logic          relax_tail,
	input  logic          tree_head,
	input  logic [NB-1:0] parent_head,
	input  logic [W-1:0]  key_head
);

	state_t        state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [NB-1:0] idx_q;
	logic [NB-1:0] root_q;
	logic [NB-1:0] pick_q;
	logic          first_q;
	logic          re_s1;
	logic [NB-1:0] col_s1;
	logic          res_valid_q;
	res_t          res_data_q;

	logic          accept, wr_ok, run_ok, scan_done, load;
	logic          clear_end, relax_end, dump_end;
	logic [NB-1:0] last_idx;

	always_comb begin
		accept = cmd.valid && cmd.ready;
		wr_ok = accept && (cmd.data.command == CMD_WRITE) &&
			(int'(cmd.data.src_node) < NODE_COUNT) &&
			(int'(cmd.data.to_node) < NODE_COUNT);
		run_ok = accept && (cmd.data.command == CMD_RUN) &&
			(int'(cmd.data.start_node) < NODE_COUNT);
		scan_done = (state_q == ST_SCAN_WAIT) && scan_tail;
		load = (state_q == ST_DUMP) && (!res_valid_q || res.ready);
		clear_end = (clr_q == AW'(NODE_COUNT * NODE_COUNT - 1));
		relax_end = (idx_q == NB'(NODE_COUNT - 1));
		dump_end = load && (idx_q == NB'(NODE_COUNT - 1));
		last_idx = (root_q == NB'(NODE_COUNT - 1)) ? NB'(NODE_COUNT - 2) :
			NB'(NODE_COUNT - 1);
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clear_end) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (run_ok) state_d = ST_INIT;
			end
			ST_INIT: begin
				state_d = ST_SCAN_GO;
			end
			ST_SCAN_GO: begin
				state_d = ST_SCAN_WAIT;
			end
			ST_SCAN_WAIT: begin
				if (scan_tail) state_d = found_tail ? ST_RELAX : ST_DUMP;
			end
			ST_RELAX: begin
				if (relax_end) state_d = ST_SETTLE;
			end
			ST_SETTLE: begin
				state_d = ST_SCAN_GO;
			end
			ST_DUMP: begin
				if (dump_end) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output logic.
	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		mem_we    = (state_q == ST_CLEAR) || wr_ok;
		mem_waddr = (state_q == ST_CLEAR) ? clr_q :
			AW'(cmd.data.src_node) * AW'(NODE_COUNT) + AW'(cmd.data.to_node);
		mem_wdata = (state_q == ST_CLEAR) ? '0 : W'(cmd.data.edge_weight);
		mem_re    = (state_q == ST_RELAX);
		mem_raddr = AW'(pick_q) * AW'(NODE_COUNT) + AW'(idx_q);
		ctl.init  = (state_q == ST_INIT);
		ctl.mark  = scan_done && found_tail;
		ctl.dump  = load;
		// Relax tokens of the previous round are still in the chain during the
		// scan wait, so they must keep seeing the current pick as their parent.
		case (state_q)
			ST_INIT:      node_sel = root_q;
			ST_SCAN_WAIT: node_sel = scan_tail ? pick_tail : pick_q;
			default:      node_sel = pick_q;
		endcase
		// The settle cycle keeps the scan token one place behind the last
		// relax token, so every cell is updated before the scan reaches it.
		scan_head         = (state_q == ST_SCAN_GO);
		relax_head        = re_s1;
		relax_col_head    = col_s1;
		relax_weight_head = mem_rdata;
		res.valid         = res_valid_q;
		res.data          = res_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			idx_q       <= '0;
			first_q     <= 1'b0;
			re_s1       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			re_s1   <= mem_re;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_INIT) begin
				first_q <= 1'b1;
			end else if (scan_done) begin
				first_q <= 1'b0;
			end
			if (scan_done) begin
				idx_q <= '0;
			end else if ((state_q == ST_RELAX) || load) begin
				idx_q <= idx_q + NB'(1);
			end
			if (load) begin
				res_valid_q <= (idx_q != root_q);
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= idx_q;
		if (run_ok) begin
			root_q <= NB'(cmd.data.start_node);
		end
		if (scan_done) begin
			pick_q <= pick_tail;
		end
		if (load) begin
			res_data_q.child_node  <= NODE_FIELD_BITS'(idx_q);
			res_data_q.parent_node <= tree_head ? NODE_FIELD_BITS'(parent_head) : '0;
			res_data_q.tree_weight <= tree_head ? WEIGHT_FIELD_BITS'(key_head) : '0;
			res_data_q.reachable   <= tree_head;
			res_data_q.last        <= (idx_q == last_idx);
		end
	end

	// The first round of a build always picks the root with a zero key.
	a_first_pick_root: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_done && first_q) |-> (found_tail && pick_tail == root_q && best_tail == '0))
		else $error("first scan of a build did not pick the root");

	a_mem_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_IDLE))
		else $error("adjacency memory written during a build");

	a_scan_tail_state: assert property (@(posedge clk) disable iff (!arst_n)
		scan_tail |-> (state_q == ST_SCAN_WAIT))
		else $error("scan result left the chain outside the scan wait");

	// Relax tokens run ahead of the scan token and must all be gone by then.
	a_relax_before_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_tail |-> !relax_tail)
		else $error("relax token still in the chain when the scan finished");

endmodule

@@ rtl/core/prim_minimum_spanning_tree.sv @@
// Minimum spanning tree engine (Prim selection over an adjacency matrix).
// Depends on pmst_pkg, pmst_stream_if, pmst_adj_mem, pmst_cell, pmst_ctrl.
//
// Usage: the cmd channel carries one transaction per command. A write
// stores one directed edge weight and gives no result; zero means no
// edge. A run names a root and produces one res transaction per non-root
// node, in index order, with last set on the final one. Writes or runs
// naming a node of NODE_COUNT or above are dropped without a result. A
// run takes an init step, then rounds in which a scan token walks the
// N-cell chain, then the chosen node's row is read from the memory port
// one entry a cycle and relaxed as it walks the chain. At most N such
// rounds happen, followed by one final scan that finds no node and then
// a dump of the results before cmd is ready again. After reset the
// matrix is cleared by a pass over all N*N entries during which cmd.ready
// is low. A result waits in an output register when res.ready is low,
// and the dump holds until the register is free.
module prim_minimum_spanning_tree import pmst_pkg::*; #(
	parameter int NODE_COUNT  = 8,
	parameter int WEIGHT_BITS = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	pmst_stream_if.sink   cmd,
	pmst_stream_if.source res
);

	localparam int NB = $clog2(NODE_COUNT);
	localparam int W  = WEIGHT_BITS;
	localparam int AW = $clog2(NODE_COUNT * NODE_COUNT);

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [W-1:0]  mem_wdata, mem_rdata;
	cell_ctl_t     ctl;
	logic [NB-1:0] node_sel;
	logic          scan_head, relax_head;
	logic [NB-1:0] relax_col_head;
	logic [W-1:0]  relax_weight_head;

	logic          scan_v [NODE_COUNT];
	logic          scan_f [NODE_COUNT];
	logic [W-1:0]  scan_b [NODE_COUNT];
	logic [NB-1:0] scan_p [NODE_COUNT];
	logic          relax_v [NODE_COUNT];
	logic [NB-1:0] relax_c [NODE_COUNT];
	logic [W-1:0]  relax_w [NODE_COUNT];
	logic          rec_t [NODE_COUNT];
	logic [NB-1:0] rec_p [NODE_COUNT];
	logic [W-1:0]  rec_k [NODE_COUNT];

	pmst_ctrl #(
		.NODE_COUNT  (NODE_COUNT),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.res               (res),
		.mem_we            (mem_we),
		.mem_waddr         (mem_waddr),
		.mem_wdata         (mem_wdata),
		.mem_re            (mem_re),
		.mem_raddr         (mem_raddr),
		.mem_rdata         (mem_rdata),
		.ctl               (ctl),
		.node_sel          (node_sel),
		.scan_head         (scan_head),
		.relax_head        (relax_head),
		.relax_col_head    (relax_col_head),
		.relax_weight_head (relax_weight_head),
		.scan_tail         (scan_v[NODE_COUNT-1]),
		.found_tail        (scan_f[NODE_COUNT-1]),
		.best_tail         (scan_b[NODE_COUNT-1]),
		.pick_tail         (scan_p[NODE_COUNT-1]),
		.relax_tail        (relax_v[NODE_COUNT-1]),
		.tree_head         (rec_t[0]),
		.parent_head       (rec_p[0]),
		.key_head          (rec_k[0])
	);

	pmst_adj_mem #(
		.DEPTH (NODE_COUNT * NODE_COUNT),
		.WIDTH (W)
	) u_adj_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	for (genvar i = 0; i < NODE_COUNT; i++) begin : g_cell
		logic          s_v_in, s_f_in, r_v_in, t_in;
		logic [W-1:0]  s_b_in, r_w_in, k_in;
		logic [NB-1:0] s_p_in, r_c_in, p_in;

		// Scan and relax tokens enter at cell 0 and move up the chain.
		if (i == 0) begin : g_head
			assign s_v_in = scan_head;
			assign s_f_in = 1'b0;
			assign s_b_in = '0;
			assign s_p_in = '0;
			assign r_v_in = relax_head;
			assign r_c_in = relax_col_head;
			assign r_w_in = relax_weight_head;
		end else begin : g_link
			assign s_v_in = scan_v[i-1];
			assign s_f_in = scan_f[i-1];
			assign s_b_in = scan_b[i-1];
			assign s_p_in = scan_p[i-1];
			assign r_v_in = relax_v[i-1];
			assign r_c_in = relax_c[i-1];
			assign r_w_in = relax_w[i-1];
		end

		// Node records move down toward cell 0 while results are dumped.
		if (i == NODE_COUNT - 1) begin : g_tail
			assign t_in = 1'b0;
			assign p_in = '0;
			assign k_in = '0;
		end else begin : g_back
			assign t_in = rec_t[i+1];
			assign p_in = rec_p[i+1];
			assign k_in = rec_k[i+1];
		end

		pmst_cell #(
			.NODE_COUNT  (NODE_COUNT),
			.WEIGHT_BITS (WEIGHT_BITS),
			.INDEX       (i)
		) u_cell (
			.clk              (clk),
			.arst_n           (arst_n),
			.ctl              (ctl),
			.node_sel         (node_sel),
			.scan_in_valid    (s_v_in),
			.scan_in_found    (s_f_in),
			.scan_in_best     (s_b_in),
			.scan_in_pick     (s_p_in),
			.scan_out_valid   (scan_v[i]),
			.scan_out_found   (scan_f[i]),
			.scan_out_best    (scan_b[i]),
			.scan_out_pick    (scan_p[i]),
			.relax_in_valid   (r_v_in),
			.relax_in_col     (r_c_in),
			.relax_in_weight  (r_w_in),
			.relax_out_valid  (relax_v[i]),
			.relax_out_col    (relax_c[i]),
			.relax_out_weight (relax_w[i]),
			.rec_in_tree      (t_in),
			.rec_in_parent    (p_in),
			.rec_in_key       (k_in),
			.rec_tree         (rec_t[i]),
			.rec_parent       (rec_p[i]),
			.rec_key          (rec_k[i])
		);
	end

endmodule
